[rtl/core/six_step_commutation_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the six-step commutation sequencer.
// ----------------------------------------------------------------------------
`ifndef SIX_STEP_COMMUTATION_SEQUENCER_MACROS_SVH
`define SIX_STEP_COMMUTATION_SEQUENCER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SSCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SSCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sscs_pkg.sv]
// ----------------------------------------------------------------------------
// sscs_pkg
// Shared types, register indexes, step codes and the gate pattern table of
// the six-step commutation sequencer.
// ----------------------------------------------------------------------------
package sscs_pkg;

    // Default duty width and register reset values.
    localparam int          DUTY_WIDTH_DEF = 16;
    localparam logic [31:0] DUTY_MAX_RST   = 32'd10000;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_METHOD    = 2'd0;
    localparam logic [1:0] REG_DIRECTION = 2'd1;
    localparam logic [1:0] REG_DUTY_MAX  = 2'd2;

    // Modulation methods.
    localparam logic [2:0] METH_HIGH_SIDE = 3'd0;
    localparam logic [2:0] METH_COUNT     = 3'd5;

    // Rotation directions.
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;

    // Step range.
    localparam logic [2:0] STEP_FIRST = 3'd1;
    localparam logic [2:0] STEP_LAST  = 3'd6;

    // Gates, in table order.
    localparam int NUM_GATES = 6;
    localparam int GATE_HA   = 0;
    localparam int GATE_HB   = 1;
    localparam int GATE_HC   = 2;
    localparam int GATE_LA   = 3;
    localparam int GATE_LB   = 4;
    localparam int GATE_LC   = 5;

    // Table entry codes: off, commanded duty, full duty.
    localparam logic [1:0] C_Z = 2'd0;
    localparam logic [1:0] C_D = 2'd1;
    localparam logic [1:0] C_M = 2'd2;

    typedef struct packed {
        logic [2:0] method;
        logic [1:0] direction;
    } t_cfg;

    typedef struct packed {
        logic       enable;
        logic       load_step;
        logic [2:0] step_value;
    } t_item;

    // Rows are {HA, HB, HC, LA, LB, LC}, indexed by method and step minus one.
    localparam logic [11:0] PATTERN [5][6] = '{
        '{ {C_D,C_Z,C_Z,C_Z,C_M,C_Z}, {C_D,C_Z,C_Z,C_Z,C_Z,C_M},
           {C_Z,C_D,C_Z,C_Z,C_Z,C_M}, {C_Z,C_D,C_Z,C_M,C_Z,C_Z},
           {C_Z,C_Z,C_D,C_M,C_Z,C_Z}, {C_Z,C_Z,C_D,C_Z,C_M,C_Z} },
        '{ {C_M,C_Z,C_Z,C_Z,C_D,C_Z}, {C_M,C_Z,C_Z,C_Z,C_Z,C_D},
           {C_Z,C_M,C_Z,C_Z,C_Z,C_D}, {C_Z,C_M,C_Z,C_D,C_Z,C_Z},
           {C_Z,C_Z,C_M,C_D,C_Z,C_Z}, {C_Z,C_Z,C_M,C_Z,C_D,C_Z} },
        '{ {C_D,C_Z,C_Z,C_D,C_M,C_Z}, {C_D,C_Z,C_Z,C_D,C_Z,C_M},
           {C_Z,C_D,C_Z,C_Z,C_D,C_M}, {C_Z,C_D,C_Z,C_M,C_D,C_Z},
           {C_Z,C_Z,C_D,C_M,C_Z,C_D}, {C_Z,C_Z,C_D,C_Z,C_M,C_D} },
        '{ {C_D,C_Z,C_Z,C_Z,C_D,C_Z}, {C_D,C_Z,C_Z,C_Z,C_Z,C_D},
           {C_Z,C_D,C_Z,C_Z,C_Z,C_D}, {C_Z,C_D,C_Z,C_D,C_Z,C_Z},
           {C_Z,C_Z,C_D,C_D,C_Z,C_Z}, {C_Z,C_Z,C_D,C_Z,C_D,C_Z} },
        '{ {C_D,C_D,C_Z,C_D,C_D,C_Z}, {C_D,C_Z,C_D,C_D,C_Z,C_D},
           {C_Z,C_D,C_D,C_Z,C_D,C_D}, {C_D,C_D,C_Z,C_D,C_D,C_Z},
           {C_D,C_Z,C_D,C_D,C_Z,C_D}, {C_Z,C_D,C_D,C_Z,C_D,C_D} }
    };

    // True for a step in the range one to six.
    function automatic logic step_ok(input logic [2:0] step);
        return (step >= STEP_FIRST) && (step <= STEP_LAST);
    endfunction

    // Gate pattern for a method and step; all gates off where either is invalid.
    function automatic logic [11:0] pattern_row(input logic [2:0] method,
                                                input logic [2:0] step);
        logic [11:0] row;
        row = '0;
        if ((method < METH_COUNT) && step_ok(step)) begin
            row = PATTERN[method][step - STEP_FIRST];
        end
        return row;
    endfunction

    // Step after this one in the given direction, with wrap.
    function automatic logic [2:0] next_step(input logic [2:0] step,
                                             input logic [1:0] dir);
        logic [2:0] nxt;
        nxt = step;
        case (dir)
            DIR_CW: begin
                nxt = ((step >= STEP_LAST) || (step == 3'd0)) ? STEP_FIRST : step + 3'd1;
            end
            DIR_CCW: begin
                nxt = ((step <= STEP_FIRST) || (step > STEP_LAST)) ? STEP_LAST : step - 3'd1;
            end
            default: begin
                nxt = step;
            end
        endcase
        return nxt;
    endfunction

endpackage

[rtl/core/sscs_apb_regs.sv]
// ----------------------------------------------------------------------------
// sscs_apb_regs
// APB register file holding the modulation method, the direction and the
// full-on duty value.
// ----------------------------------------------------------------------------
module sscs_apb_regs
    import sscs_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg,
    output logic [DUTY_WIDTH-1:0] o_duty_max
);

    logic [2:0]            r_method;
    logic [1:0]            r_direction;
    logic [DUTY_WIDTH-1:0] r_duty_max;
    logic                  w_wr;
    logic [1:0]            w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method    <= METH_HIGH_SIDE;
            r_direction <= DIR_CW;
            r_duty_max  <= DUTY_MAX_RST[DUTY_WIDTH-1:0];
        end else if (w_wr) begin
            unique case (w_idx)
                REG_METHOD:    r_method    <= pwdata[2:0];
                REG_DIRECTION: r_direction <= pwdata[1:0];
                REG_DUTY_MAX:  r_duty_max  <= pwdata[DUTY_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (w_idx)
            REG_METHOD:    prdata = {29'd0, r_method};
            REG_DIRECTION: prdata = {30'd0, r_direction};
            REG_DUTY_MAX:  prdata = 32'(r_duty_max);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.method    = r_method;
    assign o_cfg.direction = r_direction;
    assign o_duty_max      = r_duty_max;

endmodule

[rtl/core/sscs_step_engine.sv]
// ----------------------------------------------------------------------------
// sscs_step_engine
// Step state, gate pattern lookup and the result register. The held duties,
// the applied step and the update flag form the result of the last item.
// ----------------------------------------------------------------------------
`include "six_step_commutation_sequencer_macros.svh"

module sscs_step_engine
    import sscs_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  t_item                 i_item,
    input  logic [DUTY_WIDTH-1:0] i_duty,
    input  t_cfg                  i_cfg,
    input  logic [DUTY_WIDTH-1:0] i_duty_max,
    output logic [DUTY_WIDTH-1:0] o_held [NUM_GATES],
    output logic [2:0]            o_applied_step,
    output logic                  o_updated
);

    logic [2:0]            r_cur_step;
    logic [2:0]            n_cur_step;
    logic [2:0]            r_last_step;
    logic [2:0]            n_last_step;
    logic                  r_updated;
    logic                  n_updated;
    logic [DUTY_WIDTH-1:0] r_held [NUM_GATES];
    logic [DUTY_WIDTH-1:0] n_held [NUM_GATES];

    logic [2:0]            w_step;
    logic [DUTY_WIDTH-1:0] w_sat;
    logic                  w_row_ok;
    logic [11:0]           w_row;

    // Step in force for this item and the saturated duty.
    assign w_step   = i_item.load_step ? i_item.step_value : r_cur_step;
    assign w_sat    = (i_duty > i_duty_max) ? i_duty_max : i_duty;
    assign w_row_ok = (i_cfg.method < METH_COUNT) && step_ok(w_step);
    assign w_row    = pattern_row(i_cfg.method, w_step);

    // Next state for one commutation tick.
    always_comb begin
        n_cur_step  = r_cur_step;
        n_last_step = r_last_step;
        n_updated   = r_updated;
        for (int k = 0; k < NUM_GATES; k++) begin
            n_held[k] = r_held[k];
        end
        if (!i_item.enable) begin
            // A disabled tick still takes a load but does not advance.
            n_cur_step = w_step;
            n_updated  = 1'b1;
            for (int k = 0; k < NUM_GATES; k++) begin
                n_held[k] = '0;
            end
        end else begin
            n_updated   = w_row_ok;
            n_last_step = w_step;
            n_cur_step  = next_step(w_step, i_cfg.direction);
            if (w_row_ok) begin
                for (int k = 0; k < NUM_GATES; k++) begin
                    case (w_row[2*(NUM_GATES-1-k) +: 2])
                        C_D:     n_held[k] = w_sat;
                        C_M:     n_held[k] = i_duty_max;
                        default: n_held[k] = '0;
                    endcase
                end
            end
        end
    end

    // State and result register, loaded once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_step  <= STEP_FIRST;
            r_last_step <= STEP_FIRST;
            r_updated   <= 1'b0;
            for (int k = 0; k < NUM_GATES; k++) begin
                r_held[k] <= '0;
            end
        end else if (i_advance) begin
            r_cur_step  <= n_cur_step;
            r_last_step <= n_last_step;
            r_updated   <= n_updated;
            for (int k = 0; k < NUM_GATES; k++) begin
                r_held[k] <= n_held[k];
            end
        end
    end

    assign o_held         = r_held;
    assign o_applied_step = r_last_step;
    assign o_updated      = r_updated;

    // A disabled tick clears every gate and reports an update.
    `SSCS_ASSERT_NEXT(a_disable_clears, i_clk, i_rst_n,
        i_advance && !i_item.enable,
        r_updated && (r_held[GATE_HA] == '0) && (r_held[GATE_HB] == '0) &&
        (r_held[GATE_HC] == '0) && (r_held[GATE_LA] == '0) &&
        (r_held[GATE_LB] == '0) && (r_held[GATE_LC] == '0),
        "disabled item did not clear the gate duties")

    // Without an item the step state and flag stay put.
    `SSCS_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n,
        !i_advance,
        $stable(r_cur_step) && $stable(r_last_step) && $stable(r_updated),
        "step state changed without an item")

    // An unknown method leaves the duties untouched.
    `SSCS_ASSERT_NEXT(a_bad_method_holds, i_clk, i_rst_n,
        i_advance && i_item.enable && (i_cfg.method >= METH_COUNT),
        !r_updated && $stable(r_held[GATE_HA]) && $stable(r_held[GATE_LC]),
        "unknown method altered the gate duties")

    // Clockwise rotation wraps from the last step to the first.
    `SSCS_ASSERT_NEXT(a_cw_wrap, i_clk, i_rst_n,
        i_advance && i_item.enable && !i_item.load_step &&
        (i_cfg.direction == DIR_CW) && (r_cur_step == STEP_LAST),
        r_cur_step == STEP_FIRST,
        "clockwise step did not wrap to the first step")

endmodule

[rtl/core/six_step_commutation_sequencer.sv]
// An accepted item waits in the input register, then moves into the result register when that is free or draining.
// Throughput: one item per cycle while the result channel is ready; the pattern lookup
// and step counter finish within the single stage between the input and result registers.
// Reset (synchronous, active low): step 1, applied step 1, all duties zero,
// method high side, direction clockwise, duty maximum 10000.
// ----------------------------------------------------------------------------
// six_step_commutation_sequencer
// Six-step commutation sequencer for a three-phase bridge: input register,
// step engine with result register, and APB configuration registers.
// ----------------------------------------------------------------------------
module six_step_commutation_sequencer
    import sscs_pkg::*;
#(
    parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_enable,
    input  logic                  i_load_step,
    input  logic [2:0]            i_step_value,
    input  logic [DUTY_WIDTH-1:0] i_duty,
    // Result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DUTY_WIDTH-1:0] o_duty_high_a,
    output logic [DUTY_WIDTH-1:0] o_duty_high_b,
    output logic [DUTY_WIDTH-1:0] o_duty_high_c,
    output logic [DUTY_WIDTH-1:0] o_duty_low_a,
    output logic [DUTY_WIDTH-1:0] o_duty_low_b,
    output logic [DUTY_WIDTH-1:0] o_duty_low_c,
    output logic [2:0]            o_applied_step,
    output logic                  o_updated
);

    t_cfg                  w_cfg;
    logic [DUTY_WIDTH-1:0] w_duty_max;
    logic [DUTY_WIDTH-1:0] w_held [NUM_GATES];

    logic                  r_in_vld;
    t_item                 r_in_item;
    logic [DUTY_WIDTH-1:0] r_in_duty;
    logic                  r_out_vld;
    logic                  w_advance;
    logic                  w_take;

    // An item moves into the engine when the result register is free or draining.
    assign w_advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready   = !r_in_vld || w_advance;
    assign w_take    = i_valid && o_ready;

    // Input register valid and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (w_advance) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_item.enable     <= i_enable;
            r_in_item.load_step  <= i_load_step;
            r_in_item.step_value <= i_step_value;
            r_in_duty            <= i_duty;
        end
    end

    sscs_apb_regs #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (w_cfg),
        .o_duty_max (w_duty_max)
    );

    sscs_step_engine #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_item         (r_in_item),
        .i_duty         (r_in_duty),
        .i_cfg          (w_cfg),
        .i_duty_max     (w_duty_max),
        .o_held         (w_held),
        .o_applied_step (o_applied_step),
        .o_updated      (o_updated)
    );

    assign o_valid       = r_out_vld;
    assign o_duty_high_a = w_held[GATE_HA];
    assign o_duty_high_b = w_held[GATE_HB];
    assign o_duty_high_c = w_held[GATE_HC];
    assign o_duty_low_a  = w_held[GATE_LA];
    assign o_duty_low_b  = w_held[GATE_LB];
    assign o_duty_low_c  = w_held[GATE_LC];

endmodule

[dv/tb_six_step_commutation_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_six_step_commutation_sequencer
// Self-checking testbench for the six-step commutation sequencer. Commutation
// ticks are sent over the input handshake and every result item is compared,
// field by field, with a prediction from an independent model of the step
// engine. The configuration port sets the method, direction and duty ceiling
// between phases. A directed part covers the reset state, step loads, wrap,
// invalid steps and every method, followed by random traffic under varied
// back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_six_step_commutation_sequencer;
    import sscs_pkg::*;

    // Method and direction codes that the package does not name.
    localparam logic [2:0] MOD_LOW_SIDE   = 3'd1;
    localparam logic [2:0] MOD_HIGH_SYNC  = 3'd2;
    localparam logic [2:0] MOD_TWO_PHASE  = 3'd3;
    localparam logic [2:0] MOD_HL_SYNC    = 3'd4;
    localparam logic [2:0] MOD_UNDEF_LAST = 3'd7;
    localparam logic [1:0] DIR_UNDEF      = 2'd3;

    // Step codes outside the valid range.
    localparam logic [2:0] STEP_BELOW = 3'd0;
    localparam logic [2:0] STEP_ABOVE = 3'd7;

    localparam logic [15:0] DUTY_TOP      = 16'hFFFF;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          RUN_LIMIT_NS  = 4_000_000;
    localparam int          REPORT_LIMIT  = 10;

    // Gate usage per method and step, each row {HA, HB, HC, LA, LB, LC}.
    localparam logic [0:4][0:5][11:0] GATE_MAP = {
        {C_D,C_Z,C_Z,C_Z,C_M,C_Z}, {C_D,C_Z,C_Z,C_Z,C_Z,C_M},
        {C_Z,C_D,C_Z,C_Z,C_Z,C_M}, {C_Z,C_D,C_Z,C_M,C_Z,C_Z},
        {C_Z,C_Z,C_D,C_M,C_Z,C_Z}, {C_Z,C_Z,C_D,C_Z,C_M,C_Z},

        {C_M,C_Z,C_Z,C_Z,C_D,C_Z}, {C_M,C_Z,C_Z,C_Z,C_Z,C_D},
        {C_Z,C_M,C_Z,C_Z,C_Z,C_D}, {C_Z,C_M,C_Z,C_D,C_Z,C_Z},
        {C_Z,C_Z,C_M,C_D,C_Z,C_Z}, {C_Z,C_Z,C_M,C_Z,C_D,C_Z},

        {C_D,C_Z,C_Z,C_D,C_M,C_Z}, {C_D,C_Z,C_Z,C_D,C_Z,C_M},
        {C_Z,C_D,C_Z,C_Z,C_D,C_M}, {C_Z,C_D,C_Z,C_M,C_D,C_Z},
        {C_Z,C_Z,C_D,C_M,C_Z,C_D}, {C_Z,C_Z,C_D,C_Z,C_M,C_D},

        {C_D,C_Z,C_Z,C_Z,C_D,C_Z}, {C_D,C_Z,C_Z,C_Z,C_Z,C_D},
        {C_Z,C_D,C_Z,C_Z,C_Z,C_D}, {C_Z,C_D,C_Z,C_D,C_Z,C_Z},
        {C_Z,C_Z,C_D,C_D,C_Z,C_Z}, {C_Z,C_Z,C_D,C_Z,C_D,C_Z},

        {C_D,C_D,C_Z,C_D,C_D,C_Z}, {C_D,C_Z,C_D,C_D,C_Z,C_D},
        {C_Z,C_D,C_D,C_Z,C_D,C_D}, {C_D,C_D,C_Z,C_D,C_D,C_Z},
        {C_D,C_Z,C_D,C_D,C_Z,C_D}, {C_Z,C_D,C_D,C_Z,C_D,C_D}
    };

    // One expected result item: six gate duties, applied step, update flag.
    typedef struct packed {
        logic [5:0][15:0] gates;
        logic [2:0]       applied;
        logic             updated;
    } t_tick_result;

    // Clock, reset and block ports.
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid  = 1'b0;
    logic        o_ready;
    logic        i_enable     = 1'b0;
    logic        i_load_step  = 1'b0;
    logic [2:0]  i_step_value = '0;
    logic [15:0] i_duty       = '0;
    logic        o_valid;
    logic        i_ready  = 1'b0;
    logic [15:0] o_duty_high_a, o_duty_high_b, o_duty_high_c;
    logic [15:0] o_duty_low_a, o_duty_low_b, o_duty_low_c;
    logic [2:0]  o_applied_step;
    logic        o_updated;

    // Commutation state and configuration as the testbench predicts them.
    logic [2:0]       mod_method   = METH_HIGH_SIDE;
    logic [1:0]       rot_dir      = DIR_CW;
    logic [15:0]      duty_ceiling = 16'd10000;
    logic [2:0]       step_next    = STEP_FIRST;
    logic [2:0]       step_shown   = STEP_FIRST;
    logic [5:0][15:0] gate_duty    = '0;

    t_tick_result expected_ticks[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int ticks_sent    = 0;
    int ticks_checked = 0;
    int reg_writes    = 0;
    int error_count   = 0;

    six_step_commutation_sequencer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_enable       (i_enable),
        .i_load_step    (i_load_step),
        .i_step_value   (i_step_value),
        .i_duty         (i_duty),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_duty_high_a  (o_duty_high_a),
        .o_duty_high_b  (o_duty_high_b),
        .o_duty_high_c  (o_duty_high_c),
        .o_duty_low_a   (o_duty_low_a),
        .o_duty_low_b   (o_duty_low_b),
        .o_duty_low_c   (o_duty_low_c),
        .o_applied_step (o_applied_step),
        .o_updated      (o_updated)
    );

    always #4 i_clk = ~i_clk;

    // Step after the given one in the configured direction, with wrap.
    function automatic logic [2:0] advance_step(input logic [2:0] s);
        logic [2:0] n;
        n = s;
        if (rot_dir == DIR_CW) begin
            n = ((s == STEP_BELOW) || (s >= STEP_LAST)) ? STEP_FIRST : s + 3'd1;
        end else if (rot_dir == DIR_CCW) begin
            n = ((s <= STEP_FIRST) || (s > STEP_LAST)) ? STEP_LAST : s - 3'd1;
        end
        return n;
    endfunction

    // Works out the result of one accepted tick and queues it.
    task automatic commutate_tick(input logic en, input logic ld,
                                  input logic [2:0] step_val, input logic [15:0] duty);
        logic [15:0]  duty_sat;
        logic [11:0]  row;
        t_tick_result r;
        duty_sat  = (duty > duty_ceiling) ? duty_ceiling : duty;
        r.updated = 1'b0;
        if (ld) begin
            step_next = step_val;
        end
        if (!en) begin
            gate_duty = '0;
            r.updated = 1'b1;
        end else begin
            if ((mod_method < METH_COUNT) && (step_next >= STEP_FIRST)
                    && (step_next <= STEP_LAST)) begin
                row = GATE_MAP[mod_method][step_next - STEP_FIRST];
                for (int g = 0; g < NUM_GATES; g++) begin
                    case (row[11 - 2*g -: 2])
                        C_D: gate_duty[g] = duty_sat;
                        C_M: gate_duty[g] = duty_ceiling;
                        default: gate_duty[g] = '0;
                    endcase
                end
                r.updated = 1'b1;
            end
            step_shown = step_next;
            step_next  = advance_step(step_next);
        end
        r.gates   = gate_duty;
        r.applied = step_shown;
        expected_ticks.push_back(r);
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            report_error($sformatf("%s expected %0d, got %0d", name, exp_v, act_v));
        end
    endtask

    // Receiver: random back-pressure, and every accepted result is checked.
    always @(posedge i_clk) begin
        t_tick_result e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (o_valid && i_ready) begin
                if (expected_ticks.size() == 0) begin
                    report_error("result item with no tick outstanding");
                end else begin
                    e = expected_ticks.pop_front();
                    ticks_checked++;
                    compare_field("duty_high_a", e.gates[GATE_HA], o_duty_high_a);
                    compare_field("duty_high_b", e.gates[GATE_HB], o_duty_high_b);
                    compare_field("duty_high_c", e.gates[GATE_HC], o_duty_high_c);
                    compare_field("duty_low_a", e.gates[GATE_LA], o_duty_low_a);
                    compare_field("duty_low_b", e.gates[GATE_LB], o_duty_low_b);
                    compare_field("duty_low_c", e.gates[GATE_LC], o_duty_low_c);
                    compare_field("applied_step", 16'(e.applied), 16'(o_applied_step));
                    compare_field("updated", 16'(e.updated), 16'(o_updated));
                end
            end
        end
    end

    // Sends one tick, with a random gap first, and predicts its result.
    task automatic send_tick(input logic en, input logic ld,
                             input logic [2:0] step_val, input logic [15:0] duty);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_enable     <= en;
        i_load_step  <= ld;
        i_step_value <= step_val;
        i_duty       <= duty;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        ticks_sent++;
        commutate_tick(en, ld, step_val, duty);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_ticks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        case (idx)
            REG_METHOD:    mod_method   = value[2:0];
            REG_DIRECTION: rot_dir      = value[1:0];
            REG_DUTY_MAX:  duty_ceiling = value[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [2:0] m, input logic [1:0] d,
                             input logic [15:0] ceiling);
        write_reg(REG_METHOD, 32'(m));
        write_reg(REG_DIRECTION, 32'(d));
        write_reg(REG_DUTY_MAX, 32'(ceiling));
    endtask

    // Reset values: high side method, clockwise, ceiling 10000, step 1.
    task automatic test_reset_state();
        send_tick(1'b1, 1'b0, STEP_BELOW, 16'd0);
        send_tick(1'b1, 1'b0, STEP_BELOW, DUTY_TOP);
        send_tick(1'b1, 1'b0, STEP_BELOW, 16'd10000);
        send_tick(1'b1, 1'b0, STEP_BELOW, 16'd9999);
        send_tick(1'b1, 1'b0, STEP_BELOW, 16'd10001);
    endtask

    // Wrap in both directions, loads on disabled ticks and invalid steps.
    task automatic test_step_loads_and_wrap();
        send_tick(1'b1, 1'b0, STEP_BELOW, 16'd4321);
        send_tick(1'b0, 1'b1, 3'd3, 16'd500);
        send_tick(1'b1, 1'b0, STEP_BELOW, 16'd500);
        send_tick(1'b1, 1'b1, STEP_BELOW, 16'd700);
        send_tick(1'b1, 1'b1, STEP_ABOVE, 16'd800);
        write_reg(REG_DIRECTION, 32'(DIR_CCW));
        send_tick(1'b1, 1'b1, STEP_FIRST, 16'd1234);
        send_tick(1'b1, 1'b0, STEP_BELOW, 16'd2345);
        send_tick(1'b1, 1'b1, STEP_ABOVE, 16'd3456);
        send_tick(1'b1, 1'b1, STEP_BELOW, 16'd4567);
    endtask

    // Every method but high side, the undefined ones included, on one step each.
    task automatic test_methods();
        logic [2:0] methods [6];
        methods = '{MOD_LOW_SIDE, MOD_HIGH_SYNC, MOD_TWO_PHASE, MOD_HL_SYNC,
                    METH_COUNT, MOD_UNDEF_LAST};
        write_reg(REG_DIRECTION, 32'(DIR_CW));
        foreach (methods[i]) begin
            write_reg(REG_METHOD, 32'(methods[i]));
            send_tick(1'b1, 1'b1, 3'd4, 16'd6000 + 16'(i));
        end
    endtask

    // Stopped and undefined directions, and both extremes of the ceiling.
    task automatic test_direction_and_limits();
        configure(MOD_HIGH_SYNC, DIR_STOP, 16'd10000);
        send_tick(1'b1, 1'b1, 3'd2, 16'd3000);
        send_tick(1'b1, 1'b0, STEP_BELOW, 16'd3001);
        drain_results();
        write_reg(REG_DIRECTION, 32'(DIR_UNDEF));
        send_tick(1'b1, 1'b0, STEP_BELOW, 16'd3002);
        configure(METH_HIGH_SIDE, DIR_CW, 16'd0);
        send_tick(1'b1, 1'b0, STEP_BELOW, DUTY_TOP);
        write_reg(REG_DUTY_MAX, 32'(DUTY_TOP));
        send_tick(1'b1, 1'b1, 3'd5, DUTY_TOP);
    endtask

    // Random settings, mostly running sequences, with some loads and noise.
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                       input int n_ticks);
        int          sent;
        int          seg;
        logic [2:0]  m;
        logic [1:0]  d;
        logic [15:0] ceiling;
        logic [2:0]  ns;
        logic [15:0] duty;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < n_ticks) begin
            m = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                           : 3'($urandom_range(5, 7));
            d = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(1, 2))
                                           : (($urandom_range(0, 1) == 0) ? DIR_STOP
                                                                          : DIR_UNDEF);
            case ($urandom_range(0, 7))
                0: ceiling = '0;
                1: ceiling = DUTY_TOP;
                2: ceiling = 16'd10000;
                default: ceiling = 16'($urandom);
            endcase
            configure(m, d, ceiling);
            seg = $urandom_range(20, 80);
            for (int i = 0; (i < seg) && (sent < n_ticks); i++) begin
                if ($urandom_range(0, 99) == 0) begin
                    drain_results();
                end
                ns = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 6))
                                                : (($urandom_range(0, 1) == 0) ? STEP_BELOW
                                                                               : STEP_ABOVE);
                case ($urandom_range(0, 3))
                    0: duty = 16'($urandom);
                    1: duty = 16'($urandom_range(0, duty_ceiling));
                    2: duty = duty_ceiling + 16'($urandom_range(0, 2));
                    default: duty = ($urandom_range(0, 1) == 0) ? 16'd0 : DUTY_TOP;
                endcase
                send_tick($urandom_range(0, 9) != 0, $urandom_range(0, 11) == 0, ns, duty);
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial begin
        int waited;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 30;
        recv_idle_pct = 84;
        test_reset_state();
        test_step_loads_and_wrap();
        test_methods();
        test_direction_and_limits();

        test_random_traffic(30, 84, 400);
        test_random_traffic(84, 30, 400);
        test_random_traffic(0, 0, 400);

        // Let the last results come back, then watch for stray ones.
        i_valid <= 1'b0;
        waited = 0;
        while ((expected_ticks.size() != 0) && (waited < 5000)) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_ticks.size() != 0) begin
            report_error($sformatf("%0d results never arrived", expected_ticks.size()));
        end

        $display("tb: %0d ticks over five methods, undefined methods and directions,",
                 ticks_sent);
        $display("tb: %0d results checked, %0d register writes, %0d errors",
                 ticks_checked, reg_writes, error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
